### hdl/clt_pkg.sv
package clt_pkg;

    localparam int RES_MAX = 4;

    localparam logic [6:0] K_DOTS    = 7'd12;
    localparam logic [6:0] K_SINGLE  = 7'd13;
    localparam logic [6:0] K_SLASH   = 7'd22;
    localparam logic [6:0] K_KEYWORD = 7'd36;
    localparam logic [6:0] K_IDENT   = 7'd65;
    localparam logic [6:0] K_NUMBER  = 7'd66;
    localparam logic [6:0] K_STRING  = 7'd67;
    localparam logic [6:0] K_END     = 7'd68;
    localparam logic [6:0] K_ERROR   = 7'd69;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNKNOWN  = 3'd1;
    localparam logic [2:0] E_COMMENT  = 3'd2;
    localparam logic [2:0] E_CHARLIT  = 3'd3;
    localparam logic [2:0] E_STRING   = 3'd4;

    localparam int KW_NUM = 29;

    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'("void"), 64'("char"), 64'("short"), 64'("int"), 64'("long"), 64'("enum"),
        64'("signed"), 64'("unsigned"), 64'("auto"), 64'("register"), 64'("static"),
        64'("extern"), 64'("typedef"), 64'("const"), 64'("goto"), 64'("continue"),
        64'("break"), 64'("return"), 64'("if"), 64'("else"), 64'("switch"), 64'("case"),
        64'("default"), 64'("while"), 64'("do"), 64'("for"), 64'("sizeof"),
        64'("typeof"), 64'("_Alignof")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd4, 4'd5, 4'd3, 4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd8, 4'd6,
        4'd6, 4'd7, 4'd5, 4'd4, 4'd8, 4'd5, 4'd6, 4'd2, 4'd4, 4'd6, 4'd4,
        4'd7, 4'd5, 4'd2, 4'd3, 4'd6, 4'd6, 4'd8
    };

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [6:0]  token_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [63:0] number_value;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out;

    // {hit, kind}
    function automatic logic [7:0] single_kind(input logic [7:0] c);
        logic [7:0] r;
        r = 8'd0;
        unique case (c)
            "!": r = {1'b1, K_SINGLE + 7'd0};
            "%": r = {1'b1, K_SINGLE + 7'd1};
            "&": r = {1'b1, K_SINGLE + 7'd2};
            "(": r = {1'b1, K_SINGLE + 7'd3};
            ")": r = {1'b1, K_SINGLE + 7'd4};
            "*": r = {1'b1, K_SINGLE + 7'd5};
            "+": r = {1'b1, K_SINGLE + 7'd6};
            ",": r = {1'b1, K_SINGLE + 7'd7};
            "-": r = {1'b1, K_SINGLE + 7'd8};
            "/": r = {1'b1, K_SINGLE + 7'd9};
            ":": r = {1'b1, K_SINGLE + 7'd10};
            ";": r = {1'b1, K_SINGLE + 7'd11};
            "<": r = {1'b1, K_SINGLE + 7'd12};
            "=": r = {1'b1, K_SINGLE + 7'd13};
            ">": r = {1'b1, K_SINGLE + 7'd14};
            "?": r = {1'b1, K_SINGLE + 7'd15};
            "[": r = {1'b1, K_SINGLE + 7'd16};
            "]": r = {1'b1, K_SINGLE + 7'd17};
            "^": r = {1'b1, K_SINGLE + 7'd18};
            "{": r = {1'b1, K_SINGLE + 7'd19};
            "|": r = {1'b1, K_SINGLE + 7'd20};
            "}": r = {1'b1, K_SINGLE + 7'd21};
            "~": r = {1'b1, K_SINGLE + 7'd22};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] ab;
        logic [7:0]  r;
        ab = {a, b};
        unique case (ab)
            "++": r = {1'b1, 7'd0};
            "--": r = {1'b1, 7'd1};
            "==": r = {1'b1, 7'd2};
            "!=": r = {1'b1, 7'd3};
            ">=": r = {1'b1, 7'd4};
            "<=": r = {1'b1, 7'd5};
            "&&": r = {1'b1, 7'd6};
            "||": r = {1'b1, 7'd7};
            ">>": r = {1'b1, 7'd8};
            "<<": r = {1'b1, 7'd9};
            "+=": r = {1'b1, 7'd10};
            "-=": r = {1'b1, 7'd11};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_ext(input logic [7:0] c);
        return c == "+" || c == "-" || c == "=" || c == "!" ||
               c == ">" || c == "<" || c == "&" || c == "|";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        if (c >= "0" && c <= "9") begin
            r = 5'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            r = 5'(c - "a" + 8'd10);
        end else if (c >= "A" && c <= "F") begin
            r = 5'(c - "A" + 8'd10);
        end else begin
            r = 5'd16;
        end
        return r;
    endfunction

    // word bytes packed with byte 0 at [7:0]
    function automatic logic [6:0] word_kind(input logic [63:0] w, input logic [3:0] n);
        logic [6:0] r;
        logic       eq;
        r = K_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            eq = (KW_LEN[k] == n);
            for (int j = 0; j < 8; j++) begin
                if (j < int'(KW_LEN[k])) begin
                    eq = eq && (w[8*j +: 8] == KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - j) +: 8]);
                end
            end
            if (eq) begin
                r = K_KEYWORD + 7'(k);
            end
        end
        return r;
    endfunction

endpackage

### hdl/clt_lex_core.sv
module clt_lex_core import clt_pkg::*; #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_data,
    output t_out o_res [RES_MAX],
    output logic [2:0] o_cnt
);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_PUNCT, M_DOT1, M_DOT2,
        M_IDENT, M_ZERO, M_HEXX, M_NUM, M_STR, M_CHAR1, M_CHAR2
    } t_mode;

    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_OCT = 2'd1;
    localparam logic [1:0] B_HEX = 2'd2;

    localparam int OW = OFFSET_WIDTH;

    t_mode          r_mode, n_mode, m;
    logic [OW-1:0]  r_pos, n_pos, r_start, n_start, r_len, n_len;
    logic [7:0]     r_prefix [8];
    logic [7:0]     n_prefix [8];
    logic [63:0]    r_acc, n_acc;
    logic [1:0]     r_base, n_base;
    logic           r_sat, n_sat, r_halt, n_halt;

    logic [7:0]     c;
    logic [4:0]     d;
    logic           run_idle, do_add;
    logic [3:0]     add_d;
    logic [64:0]    add_r;
    logic [2:0]     cnt;
    logic [7:0]     sk, pk, ck;
    logic [63:0]    word;
    t_out           res [RES_MAX];

    function automatic logic [31:0] to32(input logic [OW-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[31:0];
    endfunction

    function automatic t_out mk(input logic [6:0] k, input logic [OW-1:0] s,
                                input logic [OW-1:0] l, input logic [63:0] v,
                                input logic [2:0] e);
        t_out r;
        r.token_kind   = k;
        r.start_offset = to32(s);
        r.token_length = to32(l);
        r.number_value = v;
        r.error_code   = e;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic logic [64:0] add_dig(input logic [63:0] a, input logic sat,
                                            input logic [1:0] base, input logic [3:0] dg);
        logic [67:0] p;
        logic [63:0] lim;
        logic [64:0] r;
        if (base == B_HEX) begin
            p   = {a, 4'd0};
            lim = '1;
        end else if (base == B_OCT) begin
            p   = {1'b0, a, 3'd0};
            lim = {1'b0, {63{1'b1}}};
        end else begin
            p   = {1'b0, a, 3'd0} + {3'd0, a, 1'b0};
            lim = {1'b0, {63{1'b1}}};
        end
        p = p + 68'(dg);
        if (sat) begin
            r = {1'b1, a};
        end else if (p > 68'(lim)) begin
            r = {1'b1, lim};
        end else begin
            r = {1'b0, p[63:0]};
        end
        return r;
    endfunction

    assign c     = i_data.text_byte;
    assign d     = hex_val(c);
    assign ck    = single_kind(c);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_len    = r_len;
        n_prefix = r_prefix;
        n_acc    = r_acc;
        n_base   = r_base;
        n_sat    = r_sat;
        n_halt   = r_halt;
        m        = r_mode;
        run_idle = 1'b0;
        do_add   = 1'b0;
        add_d    = 4'd0;
        add_r    = '0;
        sk       = '0;
        word     = '0;
        cnt      = 3'd0;
        pk       = pair_kind(r_prefix[0], c);
        for (int j = 0; j < RES_MAX; j++) begin
            res[j] = '0;
        end

        if (!r_halt) begin
            if (m == M_HEXX && d[4]) begin
                res[cnt[1:0]] = mk(K_NUMBER, r_start, OW'(1), 64'd0, E_NONE);
                cnt = cnt + 3'd1;
                n_start = r_start + OW'(1);
                n_len   = OW'(1);
                m       = M_IDENT;
                n_mode  = M_IDENT;
            end

            unique case (m)
                M_IDLE: run_idle = 1'b1;
                M_SLASH: begin
                    if (c == "/") begin
                        n_mode = M_LINE;
                    end else if (c == "*") begin
                        n_mode = M_BLOCK;
                    end else begin
                        res[cnt[1:0]] = mk(K_SLASH, n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        run_idle = 1'b1;
                    end
                end
                M_LINE: if (c == 8'h0A) n_mode = M_IDLE;
                M_BLOCK: if (c == "*") n_mode = M_BSTAR;
                M_BSTAR: begin
                    if (c == "/") begin
                        n_mode = M_IDLE;
                    end else if (c != "*") begin
                        n_mode = M_BLOCK;
                    end
                end
                M_PUNCT: begin
                    sk = single_kind(r_prefix[0]);
                    if (pk[7]) begin
                        res[cnt[1:0]] = mk(pk[6:0], n_start, OW'(2), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[1:0]] = mk(sk[6:0], n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        run_idle = 1'b1;
                    end
                end
                M_DOT1, M_DOT2: begin
                    if (c == "." && m == M_DOT1) begin
                        n_mode = M_DOT2;
                    end else if (c == ".") begin
                        res[cnt[1:0]] = mk(K_DOTS, n_start, OW'(3), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_UNKNOWN);
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (n_len < OW'(8)) begin
                            n_prefix[n_len[2:0]] = c;
                        end
                        n_len = n_len + OW'(1);
                    end else begin
                        for (int j = 0; j < 8; j++) begin
                            word[8*j +: 8] = n_prefix[j];
                        end
                        res[cnt[1:0]] = mk((n_len <= OW'(8)) ? word_kind(word, 4'(n_len)) : K_IDENT,
                                           n_start, n_len, 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        run_idle = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (c == "x" || c == "X") begin
                        n_prefix[0] = c;
                        n_len  = OW'(2);
                        n_mode = M_HEXX;
                    end else if (c >= "0" && c <= "7") begin
                        n_base = B_OCT;
                        n_mode = M_NUM;
                        do_add = 1'b1;
                        add_d  = d[3:0];
                        n_len  = OW'(2);
                    end else begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        run_idle = 1'b1;
                    end
                end
                M_HEXX: begin
                    n_base = B_HEX;
                    n_mode = M_NUM;
                    do_add = 1'b1;
                    add_d  = d[3:0];
                    n_len  = OW'(3);
                end
                M_NUM: begin
                    if (!d[4] && (r_base == B_HEX || (r_base == B_OCT && d < 5'd8) ||
                                  (r_base == B_DEC && d < 5'd10))) begin
                        do_add = 1'b1;
                        add_d  = d[3:0];
                        n_len  = n_len + OW'(1);
                    end else begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, n_len, r_acc, E_NONE);
                        cnt = cnt + 3'd1;
                        run_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        res[cnt[1:0]] = mk(K_STRING, n_start, n_len, 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        n_len = n_len + OW'(1);
                    end
                end
                M_CHAR1: begin
                    n_acc  = {{56{c[7]}}, c};
                    n_mode = M_CHAR2;
                end
                M_CHAR2: begin
                    if (c == "'") begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, OW'(3), r_acc, E_NONE);
                        cnt = cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_CHARLIT);
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                default: run_idle = 1'b1;
            endcase

            if (do_add) begin
                add_r = add_dig(n_acc, n_sat, n_base, add_d);
                n_sat = add_r[64];
                n_acc = add_r[63:0];
            end

            if (run_idle) begin
                n_mode = M_IDLE;
                if (!is_space(c)) begin
                    n_start = r_pos;
                    n_len   = OW'(1);
                    if (c == "/") begin
                        n_mode = M_SLASH;
                    end else if (c == ".") begin
                        n_mode = M_DOT1;
                    end else if (is_ext(c)) begin
                        n_prefix[0] = c;
                        n_mode = M_PUNCT;
                    end else if (ck[7]) begin
                        res[cnt[1:0]] = mk(ck[6:0], r_pos, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end else if (is_letter(c)) begin
                        n_prefix[0] = c;
                        n_mode = M_IDENT;
                    end else if (is_digit(c)) begin
                        n_acc  = 64'(c - "0");
                        n_sat  = 1'b0;
                        n_base = B_DEC;
                        n_mode = (c == "0") ? M_ZERO : M_NUM;
                    end else if (c == "\"") begin
                        n_len  = '0;
                        n_mode = M_STR;
                    end else if (c == "'") begin
                        n_mode = M_CHAR1;
                    end else begin
                        res[cnt[1:0]] = mk(K_ERROR, r_pos, '0, 64'd0, E_UNKNOWN);
                        cnt = cnt + 3'd1;
                        n_halt = 1'b1;
                    end
                end
            end

            n_pos = r_pos + OW'(1);

            if (i_data.end_of_text && !n_halt) begin
                unique case (n_mode)
                    M_SLASH: begin
                        res[cnt[1:0]] = mk(K_SLASH, n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_PUNCT: begin
                        sk = single_kind(n_prefix[0]);
                        res[cnt[1:0]] = mk(sk[6:0], n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_DOT1, M_DOT2: begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_UNKNOWN);
                        cnt = cnt + 3'd1;
                    end
                    M_IDENT: begin
                        for (int j = 0; j < 8; j++) begin
                            word[8*j +: 8] = n_prefix[j];
                        end
                        res[cnt[1:0]] = mk((n_len <= OW'(8)) ? word_kind(word, 4'(n_len)) : K_IDENT,
                                           n_start, n_len, 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_ZERO: begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_HEXX: begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                        res[cnt[1:0]] = mk(K_IDENT, n_start + OW'(1), OW'(1), 64'd0, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_NUM: begin
                        res[cnt[1:0]] = mk(K_NUMBER, n_start, n_len, n_acc, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    M_BLOCK, M_BSTAR: begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_COMMENT);
                        cnt = cnt + 3'd1;
                    end
                    M_STR: begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_STRING);
                        cnt = cnt + 3'd1;
                    end
                    M_CHAR1, M_CHAR2: begin
                        res[cnt[1:0]] = mk(K_ERROR, n_start, '0, 64'd0, E_CHARLIT);
                        cnt = cnt + 3'd1;
                    end
                    default: ;
                endcase
                if (n_mode != M_DOT1 && n_mode != M_DOT2 && n_mode != M_BLOCK &&
                    n_mode != M_BSTAR && n_mode != M_STR && n_mode != M_CHAR1 &&
                    n_mode != M_CHAR2) begin
                    res[cnt[1:0]] = mk(K_END, n_pos, '0, 64'd0, E_NONE);
                    cnt = cnt + 3'd1;
                end
                n_mode = M_IDLE;
                n_halt = 1'b1;
            end

            if (cnt != 3'd0) begin
                res[2'(cnt - 3'd1)].last_of_run = 1'b1;
            end
        end
    end

    assign o_res = res;
    assign o_cnt = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_base  <= B_DEC;
            r_sat   <= 1'b0;
            r_halt  <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_sat   <= n_sat;
            r_halt  <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

### hdl/clt_out_queue.sv
module clt_out_queue import clt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_out       i_res [RES_MAX],
    input  logic [2:0] i_cnt,
    input  logic       i_out_stall,
    output logic       o_free,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    t_out       r_buf [RES_MAX];
    logic [2:0] r_cnt;
    logic [1:0] r_rd;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_buf[r_rd];
    assign o_free      = (r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_rd  <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_rd  <= 2'd0;
        end else if (o_out_valid && !i_out_stall) begin
            r_cnt <= r_cnt - 3'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res;
        end
    end

endmodule

### hdl/c_source_tokenizer.sv
// C source tokenizer. Takes one source byte per transaction and returns the tokens it
// completes as result transactions, one per cycle while not stalled, with last_of_run
// on the final result of each byte. Each byte is lexed combinationally from the lexer
// state registers into a four-entry result buffer; a byte is taken whenever that
// buffer is empty or about to hand out its last entry. After the end token or an error
// token the block gives no more results until reset.
module c_source_tokenizer import clt_pkg::*; #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic       free;
    logic       fire;
    t_out       res [RES_MAX];
    logic [2:0] cnt;

    assign o_in_stall = !free;
    assign fire       = i_in_valid && free;

    clt_lex_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (i_in_data),
        .o_res   (res),
        .o_cnt   (cnt)
    );

    clt_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res       (res),
        .i_cnt       (cnt),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### verif/clt_token_checker.sv
module clt_token_checker import clt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_tokens
);

    typedef enum {
        LX_IDLE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR, LX_PUNCT, LX_DOT1, LX_DOT2,
        LX_WORD, LX_ZERO, LX_HEX_X, LX_NUM, LX_STR, LX_CHAR1, LX_CHAR2
    } lex_state_e;

    localparam int BASE_DEC = 0;
    localparam int BASE_OCT = 1;
    localparam int BASE_HEX = 2;

    string kw_names [29] = '{
        "void", "char", "short", "int", "long", "enum", "signed", "unsigned", "auto",
        "register", "static", "extern", "typedef", "const", "goto", "continue", "break",
        "return", "if", "else", "switch", "case", "default", "while", "do", "for",
        "sizeof", "typeof", "_Alignof"
    };
    string pair_tab [12] = '{
        "++", "--", "==", "!=", ">=", "<=", "&&", "||", ">>", "<<", "+=", "-="
    };
    string single_set = "!%&()*+,-/:;<=>?[]^{|}~";
    string ext_set    = "+-=!><&|";

    lex_state_e  lx_state;
    logic [31:0] byte_pos;
    logic [31:0] tok_start;
    logic [31:0] tok_len;
    logic [7:0]  word_buf [8];
    logic [63:0] num_acc;
    int          num_base;
    logic        num_sat;
    logic        lx_halted;

    t_out byte_tokens [$];
    t_out expected_tokens [$];

    function automatic int set_index(string s, logic [7:0] c);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic int pair_index(logic [7:0] a, logic [7:0] b);
        for (int i = 0; i < 12; i++) begin
            if (pair_tab[i][0] == a && pair_tab[i][1] == b) return i;
        end
        return -1;
    endfunction

    function automatic bit ch_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit ch_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int digit_value(logic [7:0] c);
        if (ch_digit(c)) return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return 16;
    endfunction

    function automatic logic [6:0] classify_word();
        bit same;
        if (tok_len > 8) return K_IDENT;
        for (int k = 0; k < 29; k++) begin
            same = (kw_names[k].len() == int'(tok_len));
            for (int j = 0; j < kw_names[k].len() && same; j++) begin
                same = (word_buf[j] == kw_names[k][j]);
            end
            if (same) return K_KEYWORD + 7'(k);
        end
        return K_IDENT;
    endfunction

    task automatic put_token(logic [6:0] kind, logic [31:0] start, logic [31:0] len,
                             logic [63:0] val, logic [2:0] err);
        t_out t;
        t.token_kind   = kind;
        t.start_offset = start;
        t.token_length = len;
        t.number_value = val;
        t.error_code   = err;
        t.last_of_run  = 1'b0;
        byte_tokens.push_back(t);
    endtask

    task automatic raise_error(logic [2:0] code, logic [31:0] start);
        put_token(K_ERROR, start, 0, 0, code);
        lx_halted = 1'b1;
        lx_state  = LX_IDLE;
    endtask

    task automatic add_digit(int d);
        logic [63:0] lim;
        logic [63:0] mul;
        lim = (num_base == BASE_HEX) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_FFFF_FFFF;
        mul = (num_base == BASE_DEC) ? 64'd10 : ((num_base == BASE_OCT) ? 64'd8 : 64'd16);
        if (!num_sat) begin
            if (num_acc > (lim - 64'(d)) / mul) begin
                num_acc = lim;
                num_sat = 1'b1;
            end else begin
                num_acc = num_acc * mul + 64'(d);
            end
        end
    endtask

    task automatic lex_byte(logic [7:0] c, logic [31:0] pos);
        bit again;
        int k;
        int d;
        int lim;
        again = 1'b1;
        while (again && !lx_halted) begin
            again = 1'b0;
            case (lx_state)
                LX_IDLE: begin
                    if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                        tok_start = pos;
                        tok_len   = 1;
                        if (c == "/") begin
                            lx_state = LX_SLASH;
                        end else if (c == ".") begin
                            lx_state = LX_DOT1;
                        end else if (set_index(ext_set, c) >= 0) begin
                            word_buf[0] = c;
                            lx_state    = LX_PUNCT;
                        end else if (set_index(single_set, c) >= 0) begin
                            put_token(K_SINGLE + 7'(set_index(single_set, c)), pos, 1, 0,
                                      E_NONE);
                        end else if (ch_alpha(c)) begin
                            word_buf[0] = c;
                            lx_state    = LX_WORD;
                        end else if (c == "0") begin
                            num_acc  = 0;
                            num_sat  = 1'b0;
                            num_base = BASE_DEC;
                            lx_state = LX_ZERO;
                        end else if (ch_digit(c)) begin
                            num_acc  = 64'(c - "0");
                            num_sat  = 1'b0;
                            num_base = BASE_DEC;
                            lx_state = LX_NUM;
                        end else if (c == "\"") begin
                            tok_len  = 0;
                            lx_state = LX_STR;
                        end else if (c == "'") begin
                            lx_state = LX_CHAR1;
                        end else begin
                            raise_error(E_UNKNOWN, pos);
                        end
                    end
                end
                LX_SLASH: begin
                    if (c == "/") begin
                        lx_state = LX_LINE;
                    end else if (c == "*") begin
                        lx_state = LX_BLOCK;
                    end else begin
                        put_token(K_SLASH, tok_start, 1, 0, E_NONE);
                        lx_state = LX_IDLE;
                        again    = 1'b1;
                    end
                end
                LX_LINE: begin
                    if (c == "\n") lx_state = LX_IDLE;
                end
                LX_BLOCK: begin
                    if (c == "*") lx_state = LX_BLOCK_STAR;
                end
                LX_BLOCK_STAR: begin
                    if (c == "/") begin
                        lx_state = LX_IDLE;
                    end else if (c != "*") begin
                        lx_state = LX_BLOCK;
                    end
                end
                LX_PUNCT: begin
                    k = pair_index(word_buf[0], c);
                    if (k >= 0) begin
                        put_token(7'(k), tok_start, 2, 0, E_NONE);
                        lx_state = LX_IDLE;
                    end else begin
                        k = set_index(single_set, word_buf[0]);
                        if (k >= 0) put_token(K_SINGLE + 7'(k), tok_start, 1, 0, E_NONE);
                        lx_state = LX_IDLE;
                        again    = 1'b1;
                    end
                end
                LX_DOT1: begin
                    if (c == ".") lx_state = LX_DOT2;
                    else raise_error(E_UNKNOWN, tok_start);
                end
                LX_DOT2: begin
                    if (c == ".") begin
                        put_token(K_DOTS, tok_start, 3, 0, E_NONE);
                        lx_state = LX_IDLE;
                    end else begin
                        raise_error(E_UNKNOWN, tok_start);
                    end
                end
                LX_WORD: begin
                    if (ch_alpha(c) || ch_digit(c)) begin
                        if (tok_len < 8) word_buf[tok_len] = c;
                        tok_len = tok_len + 1;
                    end else begin
                        put_token(classify_word(), tok_start, tok_len, 0, E_NONE);
                        lx_state = LX_IDLE;
                        again    = 1'b1;
                    end
                end
                LX_ZERO: begin
                    if (c == "x" || c == "X") begin
                        word_buf[0] = c;
                        tok_len     = 2;
                        lx_state    = LX_HEX_X;
                    end else if (c >= "0" && c <= "7") begin
                        num_base = BASE_OCT;
                        lx_state = LX_NUM;
                        add_digit(int'(c - "0"));
                        tok_len = 2;
                    end else begin
                        put_token(K_NUMBER, tok_start, 1, 0, E_NONE);
                        lx_state = LX_IDLE;
                        again    = 1'b1;
                    end
                end
                LX_HEX_X: begin
                    d = digit_value(c);
                    if (d < 16) begin
                        num_base = BASE_HEX;
                        lx_state = LX_NUM;
                        add_digit(d);
                        tok_len = 3;
                    end else begin
                        // the x starts an identifier one byte after the zero
                        put_token(K_NUMBER, tok_start, 1, 0, E_NONE);
                        tok_start = tok_start + 1;
                        tok_len   = 1;
                        lx_state  = LX_WORD;
                        again     = 1'b1;
                    end
                end
                LX_NUM: begin
                    d   = digit_value(c);
                    lim = (num_base == BASE_DEC) ? 10 : ((num_base == BASE_OCT) ? 8 : 16);
                    if (d < lim) begin
                        add_digit(d);
                        tok_len = tok_len + 1;
                    end else begin
                        put_token(K_NUMBER, tok_start, tok_len, num_acc, E_NONE);
                        lx_state = LX_IDLE;
                        again    = 1'b1;
                    end
                end
                LX_STR: begin
                    if (c == "\"") begin
                        put_token(K_STRING, tok_start, tok_len, 0, E_NONE);
                        lx_state = LX_IDLE;
                    end else begin
                        tok_len = tok_len + 1;
                    end
                end
                LX_CHAR1: begin
                    num_acc  = {{56{c[7]}}, c};
                    lx_state = LX_CHAR2;
                end
                LX_CHAR2: begin
                    if (c == "'") begin
                        put_token(K_NUMBER, tok_start, 3, num_acc, E_NONE);
                        lx_state = LX_IDLE;
                    end else begin
                        raise_error(E_CHARLIT, tok_start);
                    end
                end
                default: begin
                    lx_state = LX_IDLE;
                    again    = 1'b1;
                end
            endcase
        end
    endtask

    task automatic close_text();
        int k;
        bit failed;
        failed = 1'b0;
        if (!lx_halted) begin
            case (lx_state)
                LX_SLASH: put_token(K_SLASH, tok_start, 1, 0, E_NONE);
                LX_PUNCT: begin
                    k = set_index(single_set, word_buf[0]);
                    if (k >= 0) put_token(K_SINGLE + 7'(k), tok_start, 1, 0, E_NONE);
                end
                LX_DOT1, LX_DOT2: begin
                    raise_error(E_UNKNOWN, tok_start);
                    failed = 1'b1;
                end
                LX_WORD: put_token(classify_word(), tok_start, tok_len, 0, E_NONE);
                LX_ZERO: put_token(K_NUMBER, tok_start, 1, 0, E_NONE);
                LX_HEX_X: begin
                    put_token(K_NUMBER, tok_start, 1, 0, E_NONE);
                    put_token(K_IDENT, tok_start + 1, 1, 0, E_NONE);
                end
                LX_NUM: put_token(K_NUMBER, tok_start, tok_len, num_acc, E_NONE);
                LX_BLOCK, LX_BLOCK_STAR: begin
                    raise_error(E_COMMENT, tok_start);
                    failed = 1'b1;
                end
                LX_STR: begin
                    raise_error(E_STRING, tok_start);
                    failed = 1'b1;
                end
                LX_CHAR1, LX_CHAR2: begin
                    raise_error(E_CHARLIT, tok_start);
                    failed = 1'b1;
                end
                default: ;
            endcase
            if (!failed) begin
                lx_state = LX_IDLE;
                put_token(K_END, byte_pos, 0, 0, E_NONE);
                lx_halted = 1'b1;
            end
        end
    endtask

    task automatic predict_byte(t_in item);
        if (!lx_halted) begin
            byte_tokens.delete();
            lex_byte(item.text_byte, byte_pos);
            byte_pos = byte_pos + 1;
            if (item.end_of_text) close_text();
            if (byte_tokens.size() > 0) byte_tokens[$].last_of_run = 1'b1;
            foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
        end
    endtask

    task automatic note_failure(string what, t_out want, t_out got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("[%0t] %s: want kind=%0d start=%0d len=%0d val=%h err=%0d last=%0b",
                     $realtime, what, want.token_kind, want.start_offset, want.token_length,
                     want.number_value, want.error_code, want.last_of_run);
            $display("         got  kind=%0d start=%0d len=%0d val=%h err=%0d last=%0b",
                     got.token_kind, got.start_offset, got.token_length, got.number_value,
                     got.error_code, got.last_of_run);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_tokens     = 0;
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            lx_state  = LX_IDLE;
            byte_pos  = 0;
            tok_start = 0;
            tok_len   = 0;
            num_acc   = 0;
            num_base  = BASE_DEC;
            num_sat   = 1'b0;
            lx_halted = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_byte(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                o_tokens++;
                if (expected_tokens.size() == 0) begin
                    want = '0;
                    note_failure("unexpected token", want, i_out_data);
                end else begin
                    want = expected_tokens.pop_front();
                    if (want.token_kind !== i_out_data.token_kind ||
                        want.start_offset !== i_out_data.start_offset ||
                        want.token_length !== i_out_data.token_length ||
                        want.number_value !== i_out_data.number_value ||
                        want.error_code !== i_out_data.error_code ||
                        want.last_of_run !== i_out_data.last_of_run) begin
                        note_failure("token mismatch", want, i_out_data);
                    end
                end
            end
        end
        o_pending = expected_tokens.size();
    end

endmodule

### verif/c_source_tokenizer_tb.sv
module c_source_tokenizer_tb;
    import clt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BYTES = 36;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;

    int fail_count;
    int pending;
    int tokens_seen;
    int tx_pct = 27;
    int rx_pct = 64;
    int quiet_cycles = 0;

    logic [7:0] src_text [$];
    logic [7:0] tok_bytes [$];

    string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string hex_set   = "0123456789abcdefABCDEF";
    string ws_set    = " \t\n\v\f\r";
    string singles   = "!%&()*+,-/:;<=>?[]^{|}~";
    string pairs [12] = '{"++", "--", "==", "!=", ">=", "<=", "&&", "||", ">>", "<<",
                          "+=", "-="};
    string kwords [29] = '{
        "void", "char", "short", "int", "long", "enum", "signed", "unsigned", "auto",
        "register", "static", "extern", "typedef", "const", "goto", "continue", "break",
        "return", "if", "else", "switch", "case", "default", "while", "do", "for",
        "sizeof", "typeof", "_Alignof"
    };
    string tails [20] = '{
        " ", "abc", "int", "0x", "0", "017", "0x1F", "/", "+", "...", ".", "..",
        "/* q", "/* q *", "\"ab", "'", "'a", "@", "//c", "42"
    };

    c_source_tokenizer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    clt_token_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_tokens     (tokens_seen)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_str(string s);
        foreach (s[i]) src_text.push_back(s[i]);
    endtask

    task automatic tok_str(string s);
        foreach (s[i]) tok_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic gen_token();
        int n;
        logic [7:0] b;
        tok_bytes.delete();
        case ($urandom_range(13))
            0: tok_str(pairs[$urandom_range(11)]);
            1: tok_bytes.push_back(pick(singles));
            2: tok_str("...");
            3: tok_str(kwords[$urandom_range(28)]);
            4: begin
                tok_str(kwords[$urandom_range(28)]);
                tok_bytes.push_back(pick(alnum_set));
            end
            5: begin
                tok_bytes.push_back(alnum_set[$urandom_range(52)]);
                n = $urandom_range(11);
                repeat (n) tok_bytes.push_back(pick(alnum_set));
            end
            6: begin
                tok_bytes.push_back(8'("1") + 8'($urandom_range(8)));
                n = $urandom_range(3) == 0 ? $urandom_range(18, 22) : $urandom_range(4);
                repeat (n) tok_bytes.push_back(8'("0") + 8'($urandom_range(9)));
            end
            7: begin
                tok_bytes.push_back("0");
                n = $urandom_range(3) == 0 ? $urandom_range(20, 23) : $urandom_range(4);
                repeat (n) tok_bytes.push_back(8'("0") + 8'($urandom_range(7)));
                if ($urandom_range(3) == 0) tok_bytes.push_back(8'("8") + 8'($urandom_range(1)));
            end
            8: begin
                tok_bytes.push_back("0");
                tok_bytes.push_back($urandom_range(1) ? "x" : "X");
                n = $urandom_range(3) == 0 ? $urandom_range(15, 18) : $urandom_range(4);
                repeat (n) tok_bytes.push_back(pick(hex_set));
            end
            9: begin
                tok_bytes.push_back("\"");
                n = $urandom_range(6);
                repeat (n) begin
                    do b = 8'($urandom_range(255)); while (b == "\"");
                    tok_bytes.push_back(b);
                end
                tok_bytes.push_back("\"");
            end
            10: begin
                tok_bytes.push_back("'");
                tok_bytes.push_back(8'($urandom_range(255)));
                tok_bytes.push_back("'");
            end
            11: begin
                tok_str("//");
                n = $urandom_range(6);
                repeat (n) begin
                    do b = 8'($urandom_range(255)); while (b == "\n");
                    tok_bytes.push_back(b);
                end
                tok_bytes.push_back("\n");
            end
            12: begin
                tok_str("/*");
                n = $urandom_range(6);
                repeat (n) begin
                    do b = 8'($urandom_range(255)); while (b == "/");
                    tok_bytes.push_back(b);
                end
                tok_str($urandom_range(1) ? "*/" : "**/");
            end
            default: begin
                tok_bytes.push_back(alnum_set[$urandom_range(52)]);
                tok_str(pairs[$urandom_range(11)]);
                tok_bytes.push_back(8'("0") + 8'($urandom_range(9)));
            end
        endcase
        // glue tokens together now and then to exercise longest match
        if (src_text.size() > 0 && src_text[$] != "/" && tok_bytes[0] != "/" &&
            tok_bytes[0] != "*" && tok_bytes[0] != "." && $urandom_range(9) < 3) begin
        end else begin
            n = $urandom_range(1, 2);
            repeat (n) src_text.push_back(pick(ws_set));
        end
        foreach (tok_bytes[i]) src_text.push_back(tok_bytes[i]);
    endtask

    task automatic send_byte(logic [7:0] b, logic eot);
        while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{text_byte: b, end_of_text: eot};
        do @(posedge i_clk); while (in_stall);
    endtask

    initial begin
        int directed_len;
        int total;
        add_str("++--==!=>=<=&&||>><<+=-= ... ! % & ( ) * + , - / : ; < = > ");
        add_str("? [ ] ^ { | } ~ +++ a<<=b x/y */\n");
        add_str("int8 unsigned _Alignofx _Alignof ifelse do\n");
        add_str("0 0x 0xg 0X1F 0778 09 123abc 9223372036854775808 ");
        add_str("0x10000000000000000 01777777777777777777777 ");
        add_str("'a' ''' '\"' \"\" \"a b\" // c\n/* * ** */ /**/ ");
        src_text.push_back("\"");
        src_text.push_back(8'h00);
        src_text.push_back(8'hFF);
        src_text.push_back("\"");
        src_text.push_back(" ");
        src_text.push_back("'");
        src_text.push_back(8'h80);
        src_text.push_back("'");
        add_str(" ");
        directed_len = src_text.size();
        while (src_text.size() < directed_len + RANDOM_BYTES) gen_token();
        src_text.push_back(" ");
        add_str(tails[$urandom_range(19)]);
        total = src_text.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (src_text[i]) begin
            if (i == total / 3) begin
                tx_pct = 64;
                rx_pct = 27;
            end
            if (i == total / 2) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            if (i == (2 * total) / 3) begin
                tx_pct = 0;
                rx_pct = 0;
            end
            send_byte(src_text[i], i == total - 1);
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        $display("fed %0d source bytes (%0d directed), checked %0d tokens", total,
                 directed_len, tokens_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures, %0d tokens outstanding", fail_count, pending);
            $display("FAIL");
        end
        $finish;
    end

endmodule
